FILE: hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int CMP_W    = CNT_W + 1;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEL_EVAL,
      S_UP_EVAL,
      S_UP_FIN,
      S_DN_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic    wr_en;
      idx_type wr_addr;
      key_type wr_data;
      idx_type rd_addr_a;
      idx_type rd_addr_b;
   } mem_req_type;

   typedef struct packed {
      status_type status;
      key_type    removed_key;
      cnt_type    count;
   } result_type;

endpackage

FILE: hw/rtl/min_heap_priority_queue_core.sv
// Binary min-heap of signed 32-bit keys.
// Request channel (req_valid / req_stall): req_type 0 inserts req_key_value,
// 1 removes the minimum. A request is taken when req_valid is high and
// req_stall is low; req_stall stays high while a request is in progress.
// Response channel (rsp_valid / rsp_stall): one response per request with
// rsp_status (ok, overflow, underflow), rsp_removed_key (zero unless a delete
// succeeded) and rsp_entry_count (keys held afterwards, low 8 bits).
// Overflow, underflow and an insert into an empty heap go straight to the
// response; other inserts climb one level per step, and a delete reads the
// root and the last key, then descends one level per step unless the heap
// is now empty. The sift loop does one read-compare-write per cycle on a
// store with one write and two registered read ports. The next request is
// taken once the response is loaded, not before.
// The response sits in an output register; a new request is accepted while
// it waits. A stalled response holds, and a finished request behind it waits
// until the register frees.
// Reset (synchronous, active high) empties the heap at once; store contents
// are not cleared.
module min_heap_priority_queue_core
   import mhpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic signed [KEY_W-1:0] req_key_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [KEY_W-1:0] rsp_removed_key,
   output logic [7:0]              rsp_entry_count
);

   mem_req_type mem_req;
   key_type     rd_data_a, rd_data_b;
   logic        res_valid, res_ready;
   result_type  result;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [7:0]              rsp_count_ff, rsp_count_in;

   mhpq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (mem_req.wr_en),
      .wr_addr   (mem_req.wr_addr),
      .wr_data   (mem_req.wr_data),
      .rd_addr_a (mem_req.rd_addr_a),
      .rd_addr_b (mem_req.rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mhpq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_key_value (req_key_value),
      .mem_req       (mem_req),
      .rd_data_a     (rd_data_a),
      .rd_data_b     (rd_data_b),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .result        (result)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_key_in    = result.removed_key;
         rsp_count_in  = 8'(result.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_removed_key = rsp_key_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while idle was not held off");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_UNDERFLOW) |->
         (rsp_removed_key == '0 && rsp_entry_count == '0))
      else $error("underflow response with nonzero key or count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OVERFLOW) |->
         (rsp_entry_count == 8'(CAPACITY) && rsp_removed_key == '0))
      else $error("overflow response while heap not full");
`endif

endmodule

FILE: hw/rtl/mhpq_ram.sv
module mhpq_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

FILE: hw/rtl/mhpq_ctrl.sv
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  key_type     req_key_value,
   output mem_req_type mem_req,
   input  key_type     rd_data_a,
   input  key_type     rd_data_b,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  result
);

   state_type  state_ff, state_in;
   idx_type    pos_ff, pos_in;
   key_type    key_ff, key_in;
   cnt_type    count_ff, count_in;
   status_type status_ff, status_in;
   key_type    removed_ff, removed_in;

   function automatic idx_type parent_of(idx_type p);
      return (p - idx_type'(1)) >> 1;
   endfunction

   function automatic logic [IDX_W:0] left_of(idx_type p);
      return {p, 1'b1};
   endfunction

   logic [CMP_W-1:0] left_c, right_c, count_c;
   logic             left_ok, right_ok;
   idx_type          best_idx;
   key_type          best_key;
   logic             move_down;

   always_comb begin
      left_c   = CMP_W'(left_of(pos_ff));
      right_c  = left_c + CMP_W'(1);
      count_c  = CMP_W'(count_ff);
      left_ok  = (left_c < count_c) && (rd_data_a < key_ff);
      best_key = left_ok ? rd_data_a : key_ff;
      best_idx = idx_type'(left_c);
      right_ok = (right_c < count_c) && (rd_data_b < best_key);
      if (right_ok) begin
         best_idx = idx_type'(right_c);
         best_key = rd_data_b;
      end
      move_down = left_ok || right_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      mem_req    = '0;
      req_stall  = (state_ff != S_IDLE);
      res_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in  = ST_OK;
               removed_in = '0;
               if (req_type == OP_INSERT) begin
                  if (count_ff >= cnt_type'(CAPACITY)) begin
                     status_in = ST_OVERFLOW;
                     state_in  = S_RESP;
                  end else begin
                     pos_in            = idx_type'(count_ff);
                     key_in            = req_key_value;
                     count_in          = count_ff + cnt_type'(1);
                     mem_req.rd_addr_a = parent_of(idx_type'(count_ff));
                     if (count_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = req_key_value;
                        state_in        = S_RESP;
                     end else begin
                        state_in = S_UP_EVAL;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                     state_in  = S_RESP;
                  end else begin
                     mem_req.rd_addr_a = '0;
                     mem_req.rd_addr_b = idx_type'(count_ff - cnt_type'(1));
                     count_in          = count_ff - cnt_type'(1);
                     state_in          = S_DEL_EVAL;
                  end
               end
            end
         end

         S_DEL_EVAL: begin
            removed_in = rd_data_a;
            key_in     = rd_data_b;
            pos_in     = '0;
            mem_req.rd_addr_a = idx_type'(left_of('0));
            mem_req.rd_addr_b = idx_type'(left_of('0) + (IDX_W + 1)'(1));
            state_in   = (count_ff == '0) ? S_RESP : S_DN_EVAL;
         end

         S_UP_EVAL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (rd_data_a > key_ff) begin
               mem_req.wr_data   = rd_data_a;
               pos_in            = parent_of(pos_ff);
               mem_req.rd_addr_a = parent_of(parent_of(pos_ff));
               state_in          = (parent_of(pos_ff) == '0) ? S_UP_FIN : S_UP_EVAL;
            end else begin
               mem_req.wr_data = key_ff;
               state_in        = S_RESP;
            end
         end

         S_UP_FIN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            state_in        = S_RESP;
         end

         S_DN_EVAL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (move_down) begin
               mem_req.wr_data   = best_key;
               pos_in            = best_idx;
               mem_req.rd_addr_a = idx_type'(left_of(best_idx));
               mem_req.rd_addr_b = idx_type'(left_of(best_idx) + (IDX_W + 1)'(1));
            end else begin
               mem_req.wr_data = key_ff;
               state_in        = S_RESP;
            end
         end

         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.status      = status_ff;
   assign result.removed_key = removed_ff;
   assign result.count       = count_ff;

endmodule

FILE: dv/min_heap_priority_queue_core_test.sv
module min_heap_priority_queue_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mhpq_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 310;

   typedef struct {
      status_type   status;
      key_type      removed;
      logic [7:0]   count;
   } heap_result_type;

   typedef struct {
      op_type          op;
      key_type         key;
      bit              typed;
      heap_result_type want;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_type = 1'b0;
   logic signed [KEY_W-1:0] req_key_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic signed [KEY_W-1:0] rsp_removed_key;
   logic [7:0]              rsp_entry_count;

   min_heap_priority_queue_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_key_value   (req_key_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_removed_key (rsp_removed_key),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // heap shadow
   key_type         heap_keys [CAPACITY];
   int              heap_fill = 0;
   heap_result_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit              drive_typed = 1'b0;
   heap_result_type drive_want;

   int error_count   = 0;
   int quiet_cycles  = 0;
   int inserts_ok    = 0;
   int deletes_ok    = 0;
   int overflows     = 0;
   int underflows    = 0;
   int peak_fill     = 0;
   int responses     = 0;

   stim_row_type directed_rows [$];

   task automatic heap_apply(input op_type op, input key_type key,
                             output heap_result_type res);
      int pos;
      int up;
      int best;
      int lc;
      int rc;
      key_type tmp;
      res.status  = ST_OK;
      res.removed = '0;
      if (op == OP_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            res.status = ST_OVERFLOW;
            overflows++;
         end else begin
            pos = heap_fill;
            heap_keys[pos] = key;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(heap_keys[pos] < heap_keys[up])) break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[up];
               heap_keys[up] = tmp;
               pos = up;
            end
            heap_fill++;
            inserts_ok++;
            if (heap_fill > peak_fill) peak_fill = heap_fill;
         end
      end else begin
         if (heap_fill == 0) begin
            res.status = ST_UNDERFLOW;
            underflows++;
         end else begin
            res.removed = heap_keys[0];
            heap_keys[0] = heap_keys[heap_fill-1];
            heap_fill--;
            pos = 0;
            forever begin
               best = pos;
               lc = 2*pos + 1;
               rc = 2*pos + 2;
               if (lc < heap_fill && heap_keys[lc] < heap_keys[best]) best = lc;
               if (rc < heap_fill && heap_keys[rc] < heap_keys[best]) best = rc;
               if (best == pos) break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[best];
               heap_keys[best] = tmp;
               pos = best;
            end
            deletes_ok++;
         end
      end
      res.count = heap_fill[7:0];
   endtask

   function automatic key_type random_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return key_type'($signed($urandom_range(0, 15)) - 8);
      if (pick < 40) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            default: return 32'shFFFF_FFFF;
         endcase
      end
      return key_type'($urandom);
   endfunction

   task automatic add_row(input op_type op, input key_type key, input bit typed,
                          input status_type st, input key_type rm, input logic [7:0] cnt);
      stim_row_type row;
      row.op           = op;
      row.key          = key;
      row.typed        = typed;
      row.want.status  = st;
      row.want.removed = rm;
      row.want.count   = cnt;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_request(input op_type op, input key_type key, input bit typed,
                               input heap_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = op;
      req_key_value = key;
      drive_typed   = typed;
      drive_want    = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid   = 1'b0;
      drive_typed = 1'b0;
   endtask

   task automatic push_random(input op_type op);
      heap_result_type none;
      none.status  = ST_OK;
      none.removed = '0;
      none.count   = '0;
      push_request(op, random_key(), 1'b0, none);
   endtask

   task automatic run_random(input int target);
      int sent;
      int burst;
      int pick;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // fill to capacity, then run into overflow
            burst = CAPACITY - heap_fill + $urandom_range(1, 3);
            repeat (burst) push_random(OP_INSERT);
         end else if (pick < 24) begin
            // drain to empty, then underflow
            burst = heap_fill + $urandom_range(1, 2);
            repeat (burst) push_random(OP_DELETE);
         end else begin
            burst = $urandom_range(4, 24);
            repeat (burst) push_random(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_DELETE);
         end
         sent += burst;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      heap_result_type pred;
      heap_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            heap_apply(op_type'(req_type), req_key_value, pred);
            if (drive_typed) pending_results.push_back(drive_want);
            else pending_results.push_back(pred);
         end
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response status %0d key %0d count %0d",
                        $time, rsp_status, rsp_removed_key, rsp_entry_count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_removed_key !== want.removed) begin
                  error_count++;
                  $display("%0t: removed key expected %0d actual %0d",
                           $time, want.removed, rsp_removed_key);
               end
               if (rsp_entry_count !== want.count) begin
                  error_count++;
                  $display("%0t: entry count expected %0d actual %0d",
                           $time, want.count, rsp_entry_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress, %0d responses outstanding", $time, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      add_row(OP_DELETE, 32'sd0,          1, ST_UNDERFLOW, 32'sd0, 8'd0);
      add_row(OP_INSERT, 32'sh7FFF_FFFF,  1, ST_OK, 32'sd0, 8'd1);
      add_row(OP_INSERT, 32'sh8000_0000,  1, ST_OK, 32'sd0, 8'd2);
      add_row(OP_INSERT, 32'sd0,          1, ST_OK, 32'sd0, 8'd3);
      add_row(OP_INSERT, -32'sd1,         1, ST_OK, 32'sd0, 8'd4);
      add_row(OP_INSERT, -32'sd1,         1, ST_OK, 32'sd0, 8'd5);
      add_row(OP_DELETE, 32'shFFFF_FFFF,  1, ST_OK, 32'sh8000_0000, 8'd4);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, -32'sd1, 8'd3);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, -32'sd1, 8'd2);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, 32'sd0, 8'd1);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, 32'sh7FFF_FFFF, 8'd0);
      add_row(OP_DELETE, 32'sh5555_5555,  1, ST_UNDERFLOW, 32'sd0, 8'd0);
      add_row(OP_INSERT, 32'sh5555_5555,  1, ST_OK, 32'sd0, 8'd1);
      add_row(OP_INSERT, 32'shAAAA_AAAA,  1, ST_OK, 32'sd0, 8'd2);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, 32'shAAAA_AAAA, 8'd1);
      add_row(OP_DELETE, 32'sd0,          1, ST_OK, 32'sh5555_5555, 8'd0);
      add_row(OP_INSERT, 32'sd5,          0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_INSERT, -32'sd3,         0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_INSERT, 32'sd5,          0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_INSERT, 32'sd100,        0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_INSERT, -32'sd3,         0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_DELETE, 32'sd0,          0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_DELETE, 32'sd0,          0, ST_OK, 32'sd0, 8'd0);
      add_row(OP_DELETE, 32'sd0,          0, ST_OK, 32'sd0, 8'd0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 66;
      foreach (directed_rows[i])
         push_request(directed_rows[i].op, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].want);
      run_random(PHASE_ITEMS);

      send_idle_pct = 66;
      recv_idle_pct = 23;
      run_random(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_ITEMS);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d delete-mins, %0d overflows, %0d underflows",
               inserts_ok, deletes_ok, overflows, underflows);
      $display("Checked %0d responses, peak occupancy %0d of %0d, %0d mismatches",
               responses, peak_fill, CAPACITY, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
